/* hw/rtl/pat_pkg.sv */
// ----------------------------------------------------------------------------
// pat_pkg
// Shared types and constants of the page access hot tracker.
// ----------------------------------------------------------------------------
package pat_pkg;

	localparam int PAGES          = 256;
	localparam int NODES          = 8;
	localparam int TOP_PAGE_SLOTS = 4;
	localparam int CNT_W          = 16;

	localparam int PAGE_W  = $clog2(PAGES);
	localparam int NODE_W  = $clog2(NODES);
	localparam int SLOT_W  = $clog2(TOP_PAGE_SLOTS);
	localparam int SUM_W   = CNT_W + 1;
	localparam int BLEN_W  = $clog2(SUM_W + 1);
	localparam int SLACK_W = 5;
	localparam int DATA_W  = 16;

	localparam logic [DATA_W-1:0] EMPTY_READ = '1;

	// Commands
	localparam logic [2:0] CMD_ACCESS  = 3'd0;
	localparam logic [2:0] CMD_SET_MIG = 3'd1;
	localparam logic [2:0] CMD_CLR_MIG = 3'd2;
	localparam logic [2:0] CMD_CLEAR   = 3'd3;
	localparam logic [2:0] CMD_READ    = 3'd4;

	// Read selectors
	localparam logic [2:0] SEL_NODE_CNT  = 3'd0;
	localparam logic [2:0] SEL_PAGE_TOT  = 3'd1;
	localparam logic [2:0] SEL_TOP_NODE  = 3'd2;
	localparam logic [2:0] SEL_MAX_NODE  = 3'd3;
	localparam logic [2:0] SEL_TOP_PAGE  = 3'd4;
	localparam logic [2:0] SEL_MAX_PAGE  = 3'd5;

	// Configuration register indexes
	localparam logic [1:0] REG_SLACK     = 2'd0;
	localparam logic [1:0] REG_LEVEL     = 2'd1;
	localparam logic [1:0] REG_ON_TOTAL  = 2'd2;

	typedef enum logic [1:0] {
		MAG_LESS,
		MAG_SAME,
		MAG_GREATER
	} mag_t;

	// One page row of the row memory
	typedef struct packed {
		logic                              migrable;
		logic [NODE_W-1:0]                 max_node;
		logic [NODES-1:0]                  top_valid;
		logic [NODES-1:0][NODE_W-1:0]      top_node;
		logic [CNT_W-1:0]                  total;
		logic [NODES-1:0][CNT_W-1:0]       counts;
	} row_t;

endpackage

/* hw/rtl/pat_mag_unit.sv */
// ----------------------------------------------------------------------------
// pat_mag_unit
// Order-of-magnitude compare of an old and a new count by bit length.
// ----------------------------------------------------------------------------
module pat_mag_unit (
	input  logic [pat_pkg::SUM_W-1:0]   old_val,
	input  logic [pat_pkg::SUM_W-1:0]   new_val,
	input  logic [pat_pkg::SLACK_W-1:0] slack,
	output pat_pkg::mag_t               order
);
	import pat_pkg::*;

	logic [BLEN_W-1:0] old_len;
	logic [BLEN_W-1:0] new_len;
	logic [BLEN_W-1:0] diff;

	// Bit length: position of the highest set bit plus one
	always_comb begin
		old_len = '0;
		new_len = '0;
		for (int i = 0; i < SUM_W; i++) begin
			if (old_val[i]) old_len = BLEN_W'(i + 1);
			if (new_val[i]) new_len = BLEN_W'(i + 1);
		end
	end

	// Classify the growth against the slack
	always_comb begin
		if (new_val > old_val) begin
			diff  = new_len - old_len;
			order = (SLACK_W'(diff) > slack) ? MAG_GREATER : MAG_SAME;
		end else begin
			diff  = old_len - new_len;
			order = (SLACK_W'(diff) > slack) ? MAG_LESS : MAG_SAME;
		end
	end

endmodule

/* hw/rtl/page_access_hot_tracker.sv */
// ----------------------------------------------------------------------------
// page_access_hot_tracker
// Per-page and per-node access counters with hot page and hot node lists.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command item: access, set or clear migrable, clear
//   page, or read. Every item gives exactly one result item on m_axis.
//   cfg writes slack, threshold level and threshold source; cfg_ready is
//   always high and writes are meant for an idle block.
// Sequence:
//   An accepted item passes through two reads of the row memory's single
//   read port (max page row, then the item's row), two passes through the
//   shared magnitude compare unit, and an update state that writes the row
//   back and loads the result register.
//   s_axis_tready is high only between items, so a new item is accepted
//   only after the previous one has left the update state.
// Reset:
//   After arst_n releases, a clearing pass writes the reset row to all
//   256 page rows, one per cycle; no item is accepted until it is done.
// Stall:
//   The result waits in an output register; the next item may be accepted
//   meanwhile, and its update cycle holds until the register is free.
// ----------------------------------------------------------------------------
module page_access_hot_tracker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// command[2:0], page[10:3], node[13:11], cost[17:14], frozen[18],
	// read_select[21:19], zero[23:22]
	input  logic [23:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// counted[0], threshold_raised[1], read_data[17:2], zero[23:18]
	output logic [23:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import pat_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LD_MAX,
		ST_LD_ROW,
		ST_MAG_P,
		ST_MAG_N,
		ST_UPD
	} state_t;

	state_t state_q;

	// Configuration
	logic [SLACK_W-1:0] slack_q;
	logic [CNT_W-1:0]   level_q;
	logic               on_total_q;

	// Item fields
	logic [2:0]        cmd_q;
	logic [PAGE_W-1:0] page_q;
	logic [NODE_W-1:0] node_q;
	logic [3:0]        cost_q;
	logic              frozen_q;
	logic [2:0]        sel_q;

	// Tracker state
	logic [TOP_PAGE_SLOTS-1:0]             tp_valid_q;
	logic [TOP_PAGE_SLOTS-1:0][PAGE_W-1:0] tp_page_q;
	logic [PAGE_W-1:0]                     max_page_q;
	logic [SLOT_W-1:0]                     tp_cur_q;
	logic [NODE_W-1:0]                     tn_cur_q;

	// Working registers
	logic [PAGE_W-1:0] clr_cnt_q;
	logic [CNT_W-1:0]  mx_total_q;
	row_t              row_q;
	mag_t              ord_p_q;
	mag_t              ord_n_q;

	// Result register
	logic              out_valid_q;
	logic              counted_q;
	logic              thr_q;
	logic [DATA_W-1:0] rdata_q;

	// Row memory
	row_t              mem [PAGES];
	row_t              mem_rd_q;
	logic [PAGE_W-1:0] rd_addr;
	logic              wr_en;
	logic [PAGE_W-1:0] wr_addr;
	row_t              wr_data;
	row_t              reset_row;

	// Update results
	row_t                                  row_n;
	logic [TOP_PAGE_SLOTS-1:0]             tp_valid_n;
	logic [TOP_PAGE_SLOTS-1:0][PAGE_W-1:0] tp_page_n;
	logic [PAGE_W-1:0]                     max_page_n;
	logic [SLOT_W-1:0]                     tp_cur_n;
	logic [NODE_W-1:0]                     tn_cur_n;
	logic                                  access_ok;
	logic                                  thr_n;
	logic [DATA_W-1:0]                     rdata_n;
	logic [SUM_W-1:0]                      tot_sum;
	logic [SUM_W-1:0]                      node_sum;
	logic                                  here;
	logic                                  upd_go;
	logic                                  in_acc;

	// Shared magnitude unit
	logic [SUM_W-1:0] mag_old;
	logic [SUM_W-1:0] mag_new;
	mag_t             mag_ord;

	pat_mag_unit u_mag (
		.old_val(mag_old),
		.new_val(mag_new),
		.slack  (slack_q),
		.order  (mag_ord)
	);

	assign tot_sum  = SUM_W'(row_q.total) + SUM_W'(cost_q);
	assign node_sum = SUM_W'(row_q.counts[node_q]) + SUM_W'(cost_q);

	// Page pass compares against the max page, node pass against the max node
	always_comb begin
		if (state_q == ST_MAG_P) begin
			mag_old = SUM_W'(mx_total_q);
			mag_new = tot_sum;
		end else begin
			mag_old = SUM_W'(row_q.counts[row_q.max_node]);
			mag_new = node_sum;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign upd_go        = (state_q == ST_UPD) && (!out_valid_q || m_axis_tready);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, rdata_q, thr_q, counted_q};

	// Reset row
	always_comb begin
		reset_row          = '0;
		reset_row.migrable = 1'b1;
	end

	// Memory addressing
	assign rd_addr = (state_q == ST_LD_MAX) ? page_q : max_page_q;
	assign wr_en   = (state_q == ST_CLEAR) || upd_go;
	assign wr_addr = (state_q == ST_CLEAR) ? clr_cnt_q : page_q;
	assign wr_data = (state_q == ST_CLEAR) ? reset_row : row_n;

	always_ff @(posedge clk) begin
		mem_rd_q <= mem[rd_addr];
		if (wr_en) mem[wr_addr] <= wr_data;
	end

	// Apply the item to the row and the top page list, or form its read data
	always_comb begin
		row_n      = row_q;
		tp_valid_n = tp_valid_q;
		tp_page_n  = tp_page_q;
		max_page_n = max_page_q;
		tp_cur_n   = tp_cur_q;
		tn_cur_n   = tn_cur_q;
		thr_n      = 1'b0;
		rdata_n    = '0;
		here       = 1'b0;
		access_ok  = (cmd_q == CMD_ACCESS) && !frozen_q && row_q.migrable;

		case (cmd_q)
			CMD_ACCESS: begin
				if (access_ok) begin
					// Hot page list
					case (ord_p_q)
						MAG_SAME: begin
							for (int i = 0; i < TOP_PAGE_SLOTS; i++)
								if (tp_valid_q[i] && tp_page_q[i] == page_q) here = 1'b1;
							if (!here) begin
								tp_page_n[tp_cur_q]  = page_q;
								tp_valid_n[tp_cur_q] = 1'b1;
								tp_cur_n             = tp_cur_q + 1'b1;
							end
						end
						MAG_GREATER: begin
							max_page_n           = page_q;
							tp_valid_n           = '0;
							tp_page_n[tp_cur_q]  = page_q;
							tp_valid_n[tp_cur_q] = 1'b1;
							tp_cur_n             = tp_cur_q + 1'b1;
						end
						default: ;
					endcase
					// Hot node list of this page
					case (ord_n_q)
						MAG_SAME: begin
							here = 1'b0;
							for (int i = 0; i < NODES; i++)
								if (row_q.top_valid[i] && row_q.top_node[i] == node_q)
									here = 1'b1;
							if (!here) begin
								row_n.top_node[tn_cur_q]  = node_q;
								row_n.top_valid[tn_cur_q] = 1'b1;
								tn_cur_n                  = tn_cur_q + 1'b1;
							end
						end
						MAG_GREATER: begin
							row_n.max_node            = node_q;
							row_n.top_valid           = '0;
							row_n.top_node[tn_cur_q]  = node_q;
							row_n.top_valid[tn_cur_q] = 1'b1;
							tn_cur_n                  = tn_cur_q + 1'b1;
						end
						default: ;
					endcase
					// Count, or drop the row on wrap
					if (tot_sum[SUM_W-1]) begin
						row_n.counts = '0;
						row_n.total  = '0;
					end else begin
						row_n.counts[node_q] = node_sum[CNT_W-1:0];
						row_n.total          = tot_sum[CNT_W-1:0];
						thr_n = on_total_q ? (tot_sum[CNT_W-1:0] >= level_q)
						                   : (node_sum[CNT_W-1:0] >= level_q);
					end
				end
			end
			CMD_SET_MIG: row_n.migrable = 1'b1;
			CMD_CLR_MIG: row_n.migrable = 1'b0;
			CMD_CLEAR: begin
				row_n.counts    = '0;
				row_n.total     = '0;
				row_n.top_valid = '0;
				tp_valid_n      = '0;
			end
			CMD_READ: begin
				case (sel_q)
					SEL_NODE_CNT: rdata_n = row_q.counts[node_q];
					SEL_PAGE_TOT: rdata_n = row_q.total;
					SEL_TOP_NODE: rdata_n = row_q.top_valid[node_q]
					                        ? DATA_W'(row_q.top_node[node_q]) : EMPTY_READ;
					SEL_MAX_NODE: rdata_n = DATA_W'(row_q.max_node);
					SEL_TOP_PAGE: begin
						if (32'(node_q) < TOP_PAGE_SLOTS)
							rdata_n = tp_valid_q[node_q[SLOT_W-1:0]]
							          ? DATA_W'(tp_page_q[node_q[SLOT_W-1:0]]) : EMPTY_READ;
					end
					SEL_MAX_PAGE: rdata_n = DATA_W'(max_page_q);
					default: rdata_n = '0;
				endcase
			end
			default: ;
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slack_q    <= SLACK_W'(1);
			level_q    <= CNT_W'(1024);
			on_total_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SLACK:    slack_q    <= cfg_data[SLACK_W-1:0];
				REG_LEVEL:    level_q    <= cfg_data[CNT_W-1:0];
				REG_ON_TOTAL: on_total_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q    <= s_axis_tdata[2:0];
			page_q   <= s_axis_tdata[10:3];
			node_q   <= s_axis_tdata[13:11];
			cost_q   <= s_axis_tdata[17:14];
			frozen_q <= s_axis_tdata[18];
			sel_q    <= s_axis_tdata[21:19];
		end
		if (state_q == ST_LD_MAX) mx_total_q <= mem_rd_q.total;
		if (state_q == ST_LD_ROW) row_q <= mem_rd_q;
		if (state_q == ST_MAG_P) ord_p_q <= mag_ord;
		if (state_q == ST_MAG_N) ord_n_q <= mag_ord;
		if (upd_go) begin
			counted_q <= access_ok;
			thr_q     <= thr_n;
			rdata_q   <= rdata_n;
		end
	end

	// Sequencer and tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			tp_valid_q  <= '0;
			tp_page_q   <= '0;
			max_page_q  <= '0;
			tp_cur_q    <= '0;
			tn_cur_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Load the result register on update, drop it once taken
			if (upd_go) out_valid_q <= 1'b1;
			else if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == PAGE_W'(PAGES - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE:   if (in_acc) state_q <= ST_LD_MAX;
				ST_LD_MAX: state_q <= ST_LD_ROW;
				ST_LD_ROW: state_q <= ST_MAG_P;
				ST_MAG_P:  state_q <= ST_MAG_N;
				ST_MAG_N:  state_q <= ST_UPD;
				ST_UPD: begin
					if (upd_go) begin
						tp_valid_q  <= tp_valid_n;
						tp_page_q   <= tp_page_n;
						max_page_q  <= max_page_n;
						tp_cur_q    <= tp_cur_n;
						tn_cur_q    <= tn_cur_n;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Checks
	a_acc_seq: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == ST_LD_MAX)
		else $error("accepted item did not start the row loads");

	a_no_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !s_axis_tready)
		else $error("ready during clearing pass");

	a_thr_counted: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && thr_q |-> counted_q)
		else $error("threshold flag without a counted access");

	a_read_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && counted_q |-> rdata_q == '0)
		else $error("counted access carries read data");

	a_upd_frees: assert property (@(posedge clk) disable iff (!arst_n)
		upd_go |=> m_axis_tvalid && state_q == ST_IDLE)
		else $error("update did not load the result register");

endmodule

/* verif/page_access_hot_tracker_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_access_hot_tracker_test
// Self-checking bench for the page access hot tracker. A queue-fed driver
// sends command items with random gaps. A monitor compares every result
// item with a predictor that keeps its own copy of the counters, the hot
// lists and the registers. Register settings change between phases, and
// one phase drives a single page hard past the threshold on its total.
// ----------------------------------------------------------------------------
module page_access_hot_tracker_test;
	import pat_pkg::*;

	localparam int LIMIT_CYCLES = 1000000;

	typedef struct packed {
		logic        counted;
		logic        raised;
		logic [15:0] rdata;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// command, page, node, cost, frozen, read_select, zero
	logic [23:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// counted, threshold_raised, read_data, zero
	logic [23:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	page_access_hot_tracker dut (.*);

	always #5 clk = ~clk;

	// Tracker state as the bench sees it
	logic [15:0] cnt_tbl [PAGES][NODES];
	logic [15:0] total_tbl [PAGES];
	logic        mig_tbl [PAGES];
	logic [2:0]  maxnode_tbl [PAGES];
	logic [2:0]  topnode_tbl [PAGES][NODES];
	logic        topnode_ok [PAGES][NODES];
	logic [7:0]  toppage_tbl [TOP_PAGE_SLOTS];
	logic        toppage_ok [TOP_PAGE_SLOTS];
	logic [7:0]  hot_page;
	logic [1:0]  page_cursor;
	logic [2:0]  node_cursor;
	logic [4:0]  slack_reg;
	logic [15:0] level_reg;
	logic        on_total_reg;

	logic [23:0] cmd_queue [$];
	result_t     result_queue [$];
	int          fails = 0;
	int          cycles = 0;
	int          send_gap = 0;
	int          hold_gap = 0;
	bit          quiet = 0;
	bit          in_taken = 0;

	function automatic int bit_length(logic [16:0] v);
		int n;
		n = 0;
		while (v != 0) begin
			n++;
			v >>= 1;
		end
		return n;
	endfunction

	function automatic mag_t compare_mag(logic [16:0] old_v, logic [16:0] new_v);
		int bo;
		int bn;
		bo = bit_length(old_v);
		bn = bit_length(new_v);
		if (new_v > old_v)
			return (bn - bo > slack_reg) ? MAG_GREATER : MAG_SAME;
		return (bo - bn > slack_reg) ? MAG_LESS : MAG_SAME;
	endfunction

	// Update hot lists and counters for one counted access
	function automatic result_t count_access(logic [7:0] p, logic [2:0] n, logic [3:0] c);
		result_t r;
		mag_t ord;
		bit here;
		logic [2:0] mn;
		logic [15:0] v;
		r = '0;
		mn = maxnode_tbl[p];
		ord = compare_mag({1'b0, total_tbl[hot_page]}, total_tbl[p] + 17'(c));
		if (ord == MAG_SAME) begin
			here = 0;
			for (int i = 0; i < TOP_PAGE_SLOTS; i++)
				if (toppage_ok[i] && toppage_tbl[i] == p) here = 1;
			if (!here) begin
				toppage_tbl[page_cursor] = p;
				toppage_ok[page_cursor] = 1;
				page_cursor++;
			end
		end else if (ord == MAG_GREATER) begin
			hot_page = p;
			for (int i = 0; i < TOP_PAGE_SLOTS; i++) toppage_ok[i] = 0;
			toppage_tbl[page_cursor] = p;
			toppage_ok[page_cursor] = 1;
			page_cursor++;
		end
		ord = compare_mag({1'b0, cnt_tbl[p][mn]}, cnt_tbl[p][n] + 17'(c));
		if (ord == MAG_SAME) begin
			here = 0;
			for (int i = 0; i < NODES; i++)
				if (topnode_ok[p][i] && topnode_tbl[p][i] == n) here = 1;
			if (!here) begin
				topnode_tbl[p][node_cursor] = n;
				topnode_ok[p][node_cursor] = 1;
				node_cursor++;
			end
		end else if (ord == MAG_GREATER) begin
			maxnode_tbl[p] = n;
			for (int i = 0; i < NODES; i++) topnode_ok[p][i] = 0;
			topnode_tbl[p][node_cursor] = n;
			topnode_ok[p][node_cursor] = 1;
			node_cursor++;
		end
		r.counted = 1;
		if (total_tbl[p] + 17'(c) > 17'hFFFF) begin
			// wrap clears the whole row instead
			for (int i = 0; i < NODES; i++) cnt_tbl[p][i] = '0;
			total_tbl[p] = '0;
		end else begin
			cnt_tbl[p][n] += 16'(c);
			total_tbl[p] += 16'(c);
			v = on_total_reg ? total_tbl[p] : cnt_tbl[p][n];
			r.raised = (v >= level_reg);
		end
		return r;
	endfunction

	function automatic logic [15:0] read_value(logic [2:0] sel, logic [7:0] p, logic [2:0] n);
		case (sel)
			SEL_NODE_CNT: return cnt_tbl[p][n];
			SEL_PAGE_TOT: return total_tbl[p];
			SEL_TOP_NODE: return topnode_ok[p][n] ? 16'(topnode_tbl[p][n]) : EMPTY_READ;
			SEL_MAX_NODE: return 16'(maxnode_tbl[p]);
			SEL_TOP_PAGE: begin
				if (n >= TOP_PAGE_SLOTS) return '0;
				return toppage_ok[n] ? 16'(toppage_tbl[n]) : EMPTY_READ;
			end
			SEL_MAX_PAGE: return 16'(hot_page);
			default: return '0;
		endcase
	endfunction

	function automatic result_t predict_item(logic [23:0] d);
		result_t r;
		logic [2:0] cmd;
		logic [7:0] p;
		logic [2:0] n;
		cmd = d[2:0];
		p = d[10:3];
		n = d[13:11];
		r = '0;
		case (cmd)
			CMD_ACCESS:  if (!d[18] && mig_tbl[p]) r = count_access(p, n, d[17:14]);
			CMD_SET_MIG: mig_tbl[p] = 1;
			CMD_CLR_MIG: mig_tbl[p] = 0;
			CMD_CLEAR: begin
				for (int i = 0; i < NODES; i++) begin
					cnt_tbl[p][i] = '0;
					topnode_ok[p][i] = 0;
				end
				total_tbl[p] = '0;
				for (int i = 0; i < TOP_PAGE_SLOTS; i++) toppage_ok[i] = 0;
			end
			CMD_READ: r.rdata = read_value(d[21:19], p, n);
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [23:0] pack_item(logic [2:0] cmd, logic [7:0] p, logic [2:0] n,
			logic [3:0] c, logic fz, logic [2:0] sel);
		return {2'b00, sel, fz, c, n, p, cmd};
	endfunction

	// Mostly accesses on a few hot pages, with noise commands mixed in
	task automatic add_random(int count);
		logic [7:0] p;
		int k;
		for (int i = 0; i < count; i++) begin
			p = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5) * 37);
			k = $urandom_range(0, 99);
			if (k < 60)
				cmd_queue.push_back(pack_item(CMD_ACCESS, p, 3'($urandom), 4'($urandom),
					$urandom_range(0, 15) == 0, 3'($urandom)));
			else if (k < 85)
				cmd_queue.push_back(pack_item(CMD_READ, p, 3'($urandom), 4'($urandom),
					1'($urandom), 3'($urandom)));
			else if (k < 89)
				cmd_queue.push_back(pack_item(CMD_SET_MIG, p, 0, 0, 0, 0));
			else if (k < 91)
				cmd_queue.push_back(pack_item(CMD_CLR_MIG, p, 0, 0, 0, 0));
			else if (k < 95)
				cmd_queue.push_back(pack_item(CMD_CLEAR, p, 0, 0, 0, 0));
			else
				cmd_queue.push_back(pack_item(3'($urandom_range(5, 7)), p, 3'($urandom),
					4'($urandom), 1'($urandom), 3'($urandom)));
		end
	endtask

	task automatic wait_idle();
		while (cmd_queue.size() != 0 || result_queue.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_SLACK:    slack_reg = val[4:0];
			REG_LEVEL:    level_reg = val;
			REG_ON_TOTAL: on_total_reg = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_regs(logic [4:0] s, logic [15:0] l, logic t);
		wait_idle();
		write_reg(REG_SLACK, 16'(s));
		write_reg(REG_LEVEL, l);
		write_reg(REG_ON_TOTAL, 16'(t));
	endtask

	// Count cycles and stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	// Predict on every accepted command item
	always @(posedge clk) begin
		in_taken = 0;
		if (s_axis_tvalid && s_axis_tready) begin
			result_queue.push_back(predict_item(s_axis_tdata));
			in_taken = 1;
		end
	end

	// Feed command items with random idle bursts
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || in_taken)) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				s_axis_tvalid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				send_gap <= $urandom_range(0, 13);
				s_axis_tvalid <= 1'b0;
			end else if (cmd_queue.size() != 0) begin
				s_axis_tdata <= cmd_queue.pop_front();
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Stall the result side in random bursts
	always @(negedge clk) begin
		if (hold_gap > 0) begin
			hold_gap <= hold_gap - 1;
			m_axis_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			hold_gap <= $urandom_range(0, 13);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Check each result item against the oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (result_queue.size() == 0) begin
				$error("result item with no prediction: %h", m_axis_tdata);
				fails++;
			end else begin
				want = result_queue.pop_front();
				if (m_axis_tdata[0] !== want.counted) begin
					$error("counted: expected %0d, got %0d", want.counted, m_axis_tdata[0]);
					fails++;
				end
				if (m_axis_tdata[1] !== want.raised) begin
					$error("threshold_raised: expected %0d, got %0d", want.raised,
						m_axis_tdata[1]);
					fails++;
				end
				if (m_axis_tdata[17:2] !== want.rdata) begin
					$error("read_data: expected %0d, got %0d", want.rdata, m_axis_tdata[17:2]);
					fails++;
				end
			end
		end
	end

	initial begin
		for (int p = 0; p < PAGES; p++) begin
			for (int n = 0; n < NODES; n++) begin
				cnt_tbl[p][n] = '0;
				topnode_tbl[p][n] = '0;
				topnode_ok[p][n] = 0;
			end
			total_tbl[p] = '0;
			mig_tbl[p] = 1;
			maxnode_tbl[p] = '0;
		end
		for (int i = 0; i < TOP_PAGE_SLOTS; i++) begin
			toppage_tbl[i] = '0;
			toppage_ok[i] = 0;
		end
		hot_page = '0;
		page_cursor = '0;
		node_cursor = '0;
		slack_reg = 5'd1;
		level_reg = 16'd1024;
		on_total_reg = 0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty slots, odd commands and selectors, edges of fields
		cmd_queue.push_back(pack_item(CMD_READ, 0, 0, 0, 0, SEL_TOP_NODE));
		cmd_queue.push_back(pack_item(CMD_READ, 0, 3, 0, 0, SEL_TOP_PAGE));
		cmd_queue.push_back(pack_item(CMD_READ, 0, 7, 0, 0, SEL_TOP_PAGE));
		cmd_queue.push_back(pack_item(CMD_READ, 255, 7, 15, 1, 3'd6));
		cmd_queue.push_back(pack_item(CMD_READ, 255, 7, 15, 1, 3'd7));
		cmd_queue.push_back(pack_item(3'd5, 255, 7, 15, 1, 3'd7));
		cmd_queue.push_back(pack_item(3'd6, 1, 1, 1, 0, 0));
		cmd_queue.push_back(pack_item(3'd7, 2, 2, 2, 0, 0));
		cmd_queue.push_back(pack_item(CMD_ACCESS, 0, 0, 0, 0, 0));
		cmd_queue.push_back(pack_item(CMD_ACCESS, 255, 7, 15, 0, 7));
		cmd_queue.push_back(pack_item(CMD_ACCESS, 255, 7, 15, 1, 0));
		cmd_queue.push_back(pack_item(CMD_ACCESS, 0, 7, 15, 0, 0));
		cmd_queue.push_back(pack_item(CMD_CLR_MIG, 255, 0, 0, 0, 0));
		cmd_queue.push_back(pack_item(CMD_ACCESS, 255, 3, 9, 0, 0));
		cmd_queue.push_back(pack_item(CMD_SET_MIG, 255, 0, 0, 0, 0));
		cmd_queue.push_back(pack_item(CMD_ACCESS, 255, 3, 9, 0, 0));
		cmd_queue.push_back(pack_item(CMD_READ, 255, 7, 0, 0, SEL_NODE_CNT));
		cmd_queue.push_back(pack_item(CMD_READ, 255, 0, 0, 0, SEL_PAGE_TOT));
		cmd_queue.push_back(pack_item(CMD_READ, 255, 0, 0, 0, SEL_TOP_NODE));
		cmd_queue.push_back(pack_item(CMD_READ, 255, 0, 0, 0, SEL_MAX_NODE));
		cmd_queue.push_back(pack_item(CMD_READ, 0, 0, 0, 0, SEL_TOP_PAGE));
		cmd_queue.push_back(pack_item(CMD_READ, 0, 0, 0, 0, SEL_MAX_PAGE));
		cmd_queue.push_back(pack_item(CMD_CLEAR, 255, 0, 0, 0, 0));
		cmd_queue.push_back(pack_item(CMD_READ, 255, 0, 0, 0, SEL_PAGE_TOT));
		cmd_queue.push_back(pack_item(CMD_READ, 0, 1, 0, 0, SEL_TOP_PAGE));
		add_random(200);

		set_regs(5'd0, 16'd0, 1'b1);
		add_random(200);
		set_regs(5'd16, 16'd65535, 1'b0);
		add_random(200);

		// Hammer one page past the threshold on its total
		set_regs(5'd2, 16'd3000, 1'b1);
		cmd_queue.push_back(pack_item(CMD_SET_MIG, 8'd7, 0, 0, 0, 0));
		for (int i = 0; i < 240; i++)
			cmd_queue.push_back(pack_item(CMD_ACCESS, 8'd7, 3'($urandom), 4'd15, 0, 0));
		cmd_queue.push_back(pack_item(CMD_READ, 8'd7, 0, 0, 0, SEL_PAGE_TOT));

		set_regs(5'($urandom_range(0, 16)), 16'($urandom_range(0, 200)), 1'b0);
		add_random(200);
		wait_idle();
		quiet = 1;
		add_random(200);

		wait_idle();
		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
